FILE: design/fqv_pkg.sv
// Shared constants, byte codes and the base classifier for the FASTQ checker.
package fqv_pkg;

    localparam int COUNT_WIDTH_DEF    = 48;
    localparam int LINE_LEN_WIDTH_DEF = 16;
    localparam int STATUS_WIDTH       = 3;

    localparam logic [STATUS_WIDTH-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_BAD_HEADER   = 3'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_BAD_BASE     = 3'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_BAD_PLUS     = 3'd3;
    localparam logic [STATUS_WIDTH-1:0] ST_LEN_MISMATCH = 3'd4;
    localparam logic [STATUS_WIDTH-1:0] ST_EMPTY        = 3'd5;
    localparam logic [STATUS_WIDTH-1:0] ST_PARTIAL      = 3'd6;

    // Line phases of one record, in stream order.
    localparam logic [1:0] PH_HEADER   = 2'd0;
    localparam logic [1:0] PH_SEQUENCE = 2'd1;
    localparam logic [1:0] PH_PLUS     = 2'd2;
    localparam logic [1:0] PH_QUALITY  = 2'd3;

    // Item kinds carried on tuser.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_PLUS    = 8'h2B;

    typedef struct packed {
        logic gc;
        logic acgt;
        logic any;
    } base_class_t;

    // Case-insensitive match against A, C, G, T and N.
    function automatic base_class_t classify_base(input logic [7:0] b);
        base_class_t c;
        c.gc   = (b == 8'h43) || (b == 8'h63) || (b == 8'h47) || (b == 8'h67);
        c.acgt = c.gc || (b == 8'h41) || (b == 8'h61) || (b == 8'h54) || (b == 8'h74);
        c.any  = c.acgt || (b == 8'h4E) || (b == 8'h6E);
        return c;
    endfunction

endpackage

FILE: design/fqv_core.sv
// Record checker state and its registered update, one word per cycle while item_valid is high.
module fqv_core #(
    parameter int COUNT_WIDTH    = fqv_pkg::COUNT_WIDTH_DEF,
    parameter int LINE_LEN_WIDTH = fqv_pkg::LINE_LEN_WIDTH_DEF,
    parameter int RES_WIDTH      = 4 * COUNT_WIDTH + fqv_pkg::STATUS_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  logic                 item_kind,
    input  logic [7:0]           item_byte,
    output logic                 res_load,
    output logic [RES_WIDTH-1:0] res_data
);

    localparam logic [COUNT_WIDTH-1:0]    CNT_MAX = '1;
    localparam logic [LINE_LEN_WIDTH-1:0] LEN_MAX = '1;

    logic [1:0]                          phase_reg, phase_next;
    logic [LINE_LEN_WIDTH-1:0]           len_reg, len_next;
    logic [LINE_LEN_WIDTH-1:0]           seq_len_reg, seq_len_next;
    logic [COUNT_WIDTH-1:0]              lines_reg, lines_next;
    logic [COUNT_WIDTH-1:0]              base_reg, base_next;
    logic [COUNT_WIDTH-1:0]              acgt_reg, acgt_next;
    logic [COUNT_WIDTH-1:0]              gc_reg, gc_next;
    logic [fqv_pkg::STATUS_WIDTH-1:0]    err_reg, err_next;

    logic [fqv_pkg::STATUS_WIDTH-1:0]    el_err;
    logic [fqv_pkg::STATUS_WIDTH-1:0]    fin_err;
    logic [COUNT_WIDTH-1:0]              lines_inc;
    logic [COUNT_WIDTH-1:0]              fin_lines;
    logic                                pending_ok;
    fqv_pkg::base_class_t                cls;

    assign lines_inc = (lines_reg == CNT_MAX) ? lines_reg : lines_reg + 1'b1;
    assign cls       = fqv_pkg::classify_base(item_byte);

    // Verdict of closing the current line, from the registered state.
    always_comb begin
        el_err = fqv_pkg::ST_OK;
        case (phase_reg)
            fqv_pkg::PH_HEADER: begin
                if (len_reg == '0) el_err = fqv_pkg::ST_BAD_HEADER;
            end
            fqv_pkg::PH_SEQUENCE: begin
                el_err = fqv_pkg::ST_OK;
            end
            fqv_pkg::PH_PLUS: begin
                if (len_reg == '0) el_err = fqv_pkg::ST_BAD_PLUS;
            end
            default: begin
                if (len_reg != seq_len_reg) el_err = fqv_pkg::ST_LEN_MISMATCH;
            end
        endcase
    end

    // End of stream closes an unterminated line, then runs the final checks.
    always_comb begin
        pending_ok = (err_reg == fqv_pkg::ST_OK) && (len_reg != '0);
        fin_lines  = (pending_ok && el_err == fqv_pkg::ST_OK) ? lines_inc : lines_reg;
        fin_err    = err_reg;
        if (pending_ok && el_err != fqv_pkg::ST_OK) fin_err = el_err;
        if (fin_err == fqv_pkg::ST_OK) begin
            if (fin_lines == '0) begin
                fin_err = fqv_pkg::ST_EMPTY;
            end else if (fin_lines[1:0] != 2'b00) begin
                fin_err = fqv_pkg::ST_PARTIAL;
            end
        end
    end

    assign res_load = item_valid && (item_kind == fqv_pkg::KIND_EOS);
    assign res_data = {fin_err, gc_reg, acgt_reg, base_reg, 2'b00, fin_lines[COUNT_WIDTH-1:2]};

    always_comb begin
        phase_next   = phase_reg;
        len_next     = len_reg;
        seq_len_next = seq_len_reg;
        lines_next   = lines_reg;
        base_next    = base_reg;
        acgt_next    = acgt_reg;
        gc_next      = gc_reg;
        err_next     = err_reg;
        if (item_valid) begin
            if (item_kind == fqv_pkg::KIND_EOS) begin
                // The summary leaves with this word; the next byte starts fresh.
                phase_next   = fqv_pkg::PH_HEADER;
                len_next     = '0;
                seq_len_next = '0;
                lines_next   = '0;
                base_next    = '0;
                acgt_next    = '0;
                gc_next      = '0;
                err_next     = fqv_pkg::ST_OK;
            end else if (err_reg == fqv_pkg::ST_OK) begin
                if (item_byte == fqv_pkg::CH_NEWLINE) begin
                    if (el_err != fqv_pkg::ST_OK) begin
                        err_next = el_err;
                    end else begin
                        lines_next = lines_inc;
                        phase_next = phase_reg + 2'd1;
                        len_next   = '0;
                        if (phase_reg == fqv_pkg::PH_SEQUENCE) seq_len_next = len_reg;
                    end
                end else if (phase_reg == fqv_pkg::PH_HEADER && len_reg == '0
                             && item_byte != fqv_pkg::CH_AT) begin
                    err_next = fqv_pkg::ST_BAD_HEADER;
                end else if (phase_reg == fqv_pkg::PH_PLUS && len_reg == '0
                             && item_byte != fqv_pkg::CH_PLUS) begin
                    err_next = fqv_pkg::ST_BAD_PLUS;
                end else if (phase_reg == fqv_pkg::PH_SEQUENCE && !cls.any) begin
                    err_next = fqv_pkg::ST_BAD_BASE;
                end else begin
                    if (phase_reg == fqv_pkg::PH_SEQUENCE) begin
                        if (cls.gc && gc_reg != CNT_MAX) gc_next = gc_reg + 1'b1;
                        if (cls.acgt && acgt_reg != CNT_MAX) acgt_next = acgt_reg + 1'b1;
                        if (base_reg != CNT_MAX) base_next = base_reg + 1'b1;
                    end
                    if (len_reg != LEN_MAX) len_next = len_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= fqv_pkg::PH_HEADER;
            len_reg     <= '0;
            seq_len_reg <= '0;
            lines_reg   <= '0;
            base_reg    <= '0;
            acgt_reg    <= '0;
            gc_reg      <= '0;
            err_reg     <= fqv_pkg::ST_OK;
        end else begin
            phase_reg   <= phase_next;
            len_reg     <= len_next;
            seq_len_reg <= seq_len_next;
            lines_reg   <= lines_next;
            base_reg    <= base_next;
            acgt_reg    <= acgt_next;
            gc_reg      <= gc_next;
            err_reg     <= err_next;
        end
    end

    // GC bases are a subset of ACGT bases, which are a subset of all bases.
    a_count_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (gc_reg <= acgt_reg) && (acgt_reg <= base_reg))
        else $error("base counters out of order");

    // Once an error is latched, data words change nothing.
    a_error_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && item_kind == fqv_pkg::KIND_DATA && err_reg != fqv_pkg::ST_OK)
        |=> ($stable(err_reg) && $stable(base_reg) && $stable(lines_reg)
             && $stable(len_reg)))
        else $error("state moved after an error");

    // End of stream returns the checker to its reset state.
    a_eos_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |=> (lines_reg == '0 && base_reg == '0 && len_reg == '0
                      && err_reg == fqv_pkg::ST_OK && phase_reg == fqv_pkg::PH_HEADER))
        else $error("state not cleared after end of stream");

    // A completed line always restarts the length count.
    a_line_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && item_kind == fqv_pkg::KIND_DATA && err_reg == fqv_pkg::ST_OK
         && item_byte == fqv_pkg::CH_NEWLINE && el_err == fqv_pkg::ST_OK)
        |=> (len_reg == '0 && lines_reg != '0))
        else $error("line close did not restart the length");

endmodule

FILE: design/fqv_result_reg.sv
// Output register that holds one summary word until the sink takes it.
module fqv_result_reg #(
    parameter int RES_WIDTH   = 4 * fqv_pkg::COUNT_WIDTH_DEF + fqv_pkg::STATUS_WIDTH,
    parameter int TDATA_WIDTH = ((RES_WIDTH + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  logic [RES_WIDTH-1:0]   load_data,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_WIDTH-1:0] m_tdata
);

    logic                   valid_reg, valid_next;
    logic [TDATA_WIDTH-1:0] data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= TDATA_WIDTH'(load_data);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

FILE: design/fastq_validate_and_count.sv
// Top level of the FASTQ stream checker with base and GC counting.
//
// The block reads a FASTQ text stream one byte per word and takes a new word
// in every cycle, except while an end-of-stream word stalls. A word is
// registered on entry and then checked and counted by a single layer of
// compare and increment logic; an end-of-stream word loads the summary into
// the output register, which drives tvalid. Data words never produce output.
// A summary sits in an output register; while it waits, data words keep flowing
// in, and only a second end-of-stream word stalls until the first summary is
// taken. Lines cycle through header, sequence, plus and quality; the first
// format error freezes all counts and is reported in the status field of the
// summary, after which the checker clears itself for the next stream. Counters
// and line lengths saturate at their maximum value.
module fastq_validate_and_count #(
    parameter int COUNT_WIDTH    = fqv_pkg::COUNT_WIDTH_DEF,
    parameter int LINE_LEN_WIDTH = fqv_pkg::LINE_LEN_WIDTH_DEF,
    parameter int RES_WIDTH      = 4 * COUNT_WIDTH + fqv_pkg::STATUS_WIDTH,
    parameter int TDATA_WIDTH    = ((RES_WIDTH + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,  // data_byte
    input  logic                   s_tuser,  // kind: 0 data byte, 1 end of stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // From bit 0 up: reads_total, bases_total, acgt_total, gc_total,
    // status_code, zero padding.
    output logic [TDATA_WIDTH-1:0] m_tdata
);

    logic       in_valid_reg, in_valid_next;
    logic       in_kind_reg;
    logic [7:0] in_byte_reg;
    logic       advance;
    logic       res_load;
    logic [RES_WIDTH-1:0] res_data;

    // A registered word moves on unless it is an end-of-stream word and the
    // output register still holds a summary that is not being taken.
    assign advance  = in_valid_reg &&
                      (in_kind_reg == fqv_pkg::KIND_DATA || !m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) in_valid_next = s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    fqv_core #(
        .COUNT_WIDTH    (COUNT_WIDTH),
        .LINE_LEN_WIDTH (LINE_LEN_WIDTH),
        .RES_WIDTH      (RES_WIDTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (advance),
        .item_kind  (in_kind_reg),
        .item_byte  (in_byte_reg),
        .res_load   (res_load),
        .res_data   (res_data)
    );

    fqv_result_reg #(
        .RES_WIDTH   (RES_WIDTH),
        .TDATA_WIDTH (TDATA_WIDTH)
    ) u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_load),
        .load_data (res_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
